/* hw/rtl/cpu8_pkg.sv */
// Shared types and constants of the 8-bit load/store/logic unit.
package cpu8_pkg;

    typedef enum logic [3:0] {
        M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY
    } t_mode;

    typedef enum logic [4:0] {
        K_BAD, K_LD, K_ST, K_INC, K_DEC, K_AND, K_EOR, K_ORA,
        K_INX, K_INY, K_DEX, K_DEY, K_TAX, K_TAY, K_TXA, K_TYA, K_TXS, K_TSX
    } t_kind;

    typedef enum logic [1:0] {R_A, R_X, R_Y} t_reg;

    typedef struct packed {
        t_kind kind;
        t_mode mode;
        t_reg  reg_sel;
    } t_decode;

    // Memory port selection driven by the controller.
    typedef enum logic [2:0] {
        AS_CLEAR, AS_PTR_LO, AS_PTR_HI, AS_EA
    } t_addr_sel;

    typedef struct packed {
        logic      load_item;    // capture the input item and decode it
        logic      mem_rd;       // issue a memory read
        t_addr_sel addr_sel;
        logic      lat_ptr_lo;   // read data is the pointer low byte
        logic      lat_ptr_hi;   // read data is the pointer high byte
        logic      form_ea;      // compute the effective address
        logic      execute;      // update registers and memory
        logic      clear_wr;     // clearing pass write
    } t_cmd;

    typedef struct packed {
        logic  clear_done;
        t_mode mode;
        t_kind kind;
    } t_status;

    localparam logic [7:0] SIGN_BIT = 8'b1000_0000;

    function automatic t_decode decode_op(input logic [7:0] op);
        t_decode d;
        d = '{kind: K_BAD, mode: M_IMP, reg_sel: R_A};
        case (op)
            8'hA9: d = '{K_LD, M_IMM, R_A};
            8'hA5: d = '{K_LD, M_ZP,  R_A};
            8'hB5: d = '{K_LD, M_ZPX, R_A};
            8'hAD: d = '{K_LD, M_ABS, R_A};
            8'hBD: d = '{K_LD, M_ABX, R_A};
            8'hB9: d = '{K_LD, M_ABY, R_A};
            8'hA1: d = '{K_LD, M_IZX, R_A};
            8'hB1: d = '{K_LD, M_IZY, R_A};
            8'hA2: d = '{K_LD, M_IMM, R_X};
            8'hA6: d = '{K_LD, M_ZP,  R_X};
            8'hB6: d = '{K_LD, M_ZPY, R_X};
            8'hAE: d = '{K_LD, M_ABS, R_X};
            8'hBE: d = '{K_LD, M_ABY, R_X};
            8'hA0: d = '{K_LD, M_IMM, R_Y};
            8'hA4: d = '{K_LD, M_ZP,  R_Y};
            8'hB4: d = '{K_LD, M_ZPX, R_Y};
            8'hAC: d = '{K_LD, M_ABS, R_Y};
            8'hBC: d = '{K_LD, M_ABX, R_Y};
            8'h85: d = '{K_ST, M_ZP,  R_A};
            8'h95: d = '{K_ST, M_ZPX, R_A};
            8'h8D: d = '{K_ST, M_ABS, R_A};
            8'h9D: d = '{K_ST, M_ABX, R_A};
            8'h99: d = '{K_ST, M_ABY, R_A};
            8'h81: d = '{K_ST, M_IZX, R_A};
            8'h91: d = '{K_ST, M_IZY, R_A};
            8'h86: d = '{K_ST, M_ZP,  R_X};
            8'h96: d = '{K_ST, M_ZPY, R_X};
            8'h8E: d = '{K_ST, M_ABS, R_X};
            8'h84: d = '{K_ST, M_ZP,  R_Y};
            8'h94: d = '{K_ST, M_ZPX, R_Y};
            8'h8C: d = '{K_ST, M_ABS, R_Y};
            8'hE6: d = '{K_INC, M_ZP,  R_A};
            8'hF6: d = '{K_INC, M_ZPX, R_A};
            8'hEE: d = '{K_INC, M_ABS, R_A};
            8'hFE: d = '{K_INC, M_ABX, R_A};
            8'hC6: d = '{K_DEC, M_ZP,  R_A};
            8'hD6: d = '{K_DEC, M_ZPX, R_A};
            8'hCE: d = '{K_DEC, M_ABS, R_A};
            8'hDE: d = '{K_DEC, M_ABX, R_A};
            8'h29: d = '{K_AND, M_IMM, R_A};
            8'h25: d = '{K_AND, M_ZP,  R_A};
            8'h35: d = '{K_AND, M_ZPX, R_A};
            8'h2D: d = '{K_AND, M_ABS, R_A};
            8'h49: d = '{K_EOR, M_IMM, R_A};
            8'h45: d = '{K_EOR, M_ZP,  R_A};
            8'h55: d = '{K_EOR, M_ZPX, R_A};
            8'h4D: d = '{K_EOR, M_ABS, R_A};
            8'h09: d = '{K_ORA, M_IMM, R_A};
            8'h05: d = '{K_ORA, M_ZP,  R_A};
            8'h15: d = '{K_ORA, M_ZPX, R_A};
            8'h0D: d = '{K_ORA, M_ABS, R_A};
            8'hE8: d.kind = K_INX;
            8'hC8: d.kind = K_INY;
            8'hCA: d.kind = K_DEX;
            8'h88: d.kind = K_DEY;
            8'hAA: d.kind = K_TAX;
            8'hA8: d.kind = K_TAY;
            8'h8A: d.kind = K_TXA;
            8'h98: d.kind = K_TYA;
            8'h9A: d.kind = K_TXS;
            8'hBA: d.kind = K_TSX;
            default: d = '{K_BAD, M_IMP, R_A};
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/cpu8_ctrl.sv */
// Controller state machine that sequences memory accesses for one item.
module cpu8_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  cpu8_pkg::t_status i_status,
    output cpu8_pkg::t_cmd   o_cmd
);
    import cpu8_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_PLO   = 9'b000000100,
        S_PHI   = 9'b000001000,
        S_PWAIT = 9'b000010000,
        S_EA    = 9'b000100000,
        S_RD    = 9'b001000000,
        S_EXEC  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   indirect;

    assign indirect = (i_status.mode == M_IZX) || (i_status.mode == M_IZY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.addr_sel = AS_EA;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.addr_sel = AS_CLEAR;
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_PLO;
                end
            end
            S_PLO: begin
                // Decoded item is now registered.
                if (indirect) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = AS_PTR_LO;
                    n_state = S_PHI;
                end else begin
                    n_state = S_EA;
                end
            end
            S_PHI: begin
                o_cmd.mem_rd     = 1'b1;
                o_cmd.addr_sel   = AS_PTR_HI;
                o_cmd.lat_ptr_lo = 1'b1;
                n_state = S_PWAIT;
            end
            S_PWAIT: begin
                o_cmd.lat_ptr_hi = 1'b1;
                n_state = S_EA;
            end
            S_EA: begin
                o_cmd.form_ea = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = AS_EA;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

/* hw/rtl/cpu8_dpath.sv */
// Datapath: registers, data memory, address formation and result registers.
module cpu8_dpath #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpu8_pkg::t_cmd    i_cmd,
    output cpu8_pkg::t_status o_status,
    input  logic [7:0]        i_opcode,
    input  logic [7:0]        i_operand_low,
    input  logic [7:0]        i_operand_high,
    output logic [7:0]        o_acc_value,
    output logic [7:0]        o_x_value,
    output logic [7:0]        o_y_value,
    output logic [7:0]        o_stack_value,
    output logic              o_zero_out,
    output logic              o_negative_out,
    output logic [15:0]       o_effective_address,
    output logic [7:0]        o_memory_byte,
    output logic              o_illegal_opcode
);
    import cpu8_pkg::*;

    localparam int MemDepth = 1 << MEM_ADDR_BITS;

    logic [7:0] r_mem [MemDepth];

    t_decode r_dec;
    logic [7:0] r_lo, r_hi;
    logic [7:0] r_a, r_x, r_y, r_s;
    logic r_z, r_n;
    logic [7:0] r_plo, r_phi;
    logic [MEM_ADDR_BITS-1:0] r_ea, r_clr;
    logic r_clr_done;
    logic [7:0] r_rd;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0] zp_x, zp_y, ptr0;
    logic [15:0] ea_full;
    logic [7:0] sel_reg, v, res;
    logic wr_en;
    logic [7:0] wr_data;
    logic [MEM_ADDR_BITS-1:0] wr_addr;
    logic has_mem;

    assign zp_x = r_lo + r_x;
    assign zp_y = r_lo + r_y;
    assign ptr0 = (r_dec.mode == M_IZX) ? zp_x : r_lo;

    always_comb begin
        case (i_cmd.addr_sel)
            AS_PTR_LO: mem_addr = MEM_ADDR_BITS'({8'h00, ptr0});
            AS_PTR_HI: mem_addr = MEM_ADDR_BITS'({8'h00, 8'(ptr0 + 8'd1)});
            default:   mem_addr = r_ea;
        endcase
    end

    always_comb begin
        case (r_dec.mode)
            M_ZP:    ea_full = {8'h00, r_lo};
            M_ZPX:   ea_full = {8'h00, zp_x};
            M_ZPY:   ea_full = {8'h00, zp_y};
            M_ABS:   ea_full = {r_hi, r_lo};
            M_ABX:   ea_full = {r_hi, r_lo} + {8'h00, r_x};
            M_ABY:   ea_full = {r_hi, r_lo} + {8'h00, r_y};
            M_IZX:   ea_full = {r_phi, r_plo};
            M_IZY:   ea_full = {r_phi, r_plo} + {8'h00, r_y};
            default: ea_full = '0;
        endcase
    end

    assign has_mem = (r_dec.kind != K_BAD) && (r_dec.mode != M_IMP)
                     && (r_dec.mode != M_IMM);

    always_comb begin
        case (r_dec.reg_sel)
            R_X:     sel_reg = r_x;
            R_Y:     sel_reg = r_y;
            default: sel_reg = r_a;
        endcase
    end

    assign v = (r_dec.mode == M_IMM) ? r_lo : (has_mem ? r_rd : 8'h00);

    always_comb begin
        case (r_dec.kind)
            K_INC:   res = v + 8'd1;
            K_DEC:   res = v - 8'd1;
            default: res = sel_reg;
        endcase
    end

    assign wr_en = i_cmd.clear_wr ||
                   (i_cmd.execute && ((r_dec.kind == K_ST) || (r_dec.kind == K_INC)
                                      || (r_dec.kind == K_DEC)));
    assign wr_addr = i_cmd.clear_wr ? r_clr : r_ea;
    assign wr_data = i_cmd.clear_wr ? 8'h00 : res;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.mem_rd) r_rd <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clear_wr && !r_clr_done) begin
            r_clr <= r_clr + 1'b1;
            if (&r_clr) r_clr_done <= 1'b1;
        end
    end

    assign o_status = '{clear_done: r_clr_done, mode: r_dec.mode, kind: r_dec.kind};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_dec <= decode_op(i_opcode);
            r_lo  <= i_operand_low;
            r_hi  <= i_operand_high;
        end
        if (i_cmd.lat_ptr_lo) r_plo <= r_rd;
        if (i_cmd.lat_ptr_hi) r_phi <= r_rd;
        if (i_cmd.form_ea) r_ea <= ea_full[MEM_ADDR_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_x <= '0; r_y <= '0; r_s <= '0;
            r_z <= 1'b0; r_n <= 1'b0;
            o_effective_address <= '0;
            o_memory_byte <= '0;
            o_illegal_opcode <= 1'b0;
        end else if (i_cmd.execute) begin
            o_effective_address <= has_mem ? 16'(r_ea) : 16'h0000;
            // Only a memory access reports a byte; immediate and implied give zero.
            o_memory_byte <= !has_mem ? 8'h00 :
                             (((r_dec.kind == K_ST) || (r_dec.kind == K_INC)
                              || (r_dec.kind == K_DEC)) ? res : v);
            o_illegal_opcode <= (r_dec.kind == K_BAD);
            case (r_dec.kind)
                K_LD: begin
                    case (r_dec.reg_sel)
                        R_X:     r_x <= v;
                        R_Y:     r_y <= v;
                        default: r_a <= v;
                    endcase
                    r_z <= (v == 8'h00); r_n <= |(v & SIGN_BIT);
                end
                K_INC, K_DEC: begin
                    r_z <= (res == 8'h00); r_n <= |(res & SIGN_BIT);
                end
                K_AND: begin
                    r_a <= r_a & v; r_z <= ((r_a & v) == 8'h00); r_n <= r_a[7] & v[7];
                end
                K_EOR: begin
                    r_a <= r_a ^ v; r_z <= ((r_a ^ v) == 8'h00); r_n <= r_a[7] ^ v[7];
                end
                K_ORA: begin
                    r_a <= r_a | v; r_z <= ((r_a | v) == 8'h00); r_n <= r_a[7] | v[7];
                end
                K_INX: begin
                    r_x <= r_x + 8'd1; r_z <= (r_x == 8'hFF); r_n <= |((r_x + 8'd1) & SIGN_BIT);
                end
                K_INY: begin
                    r_y <= r_y + 8'd1; r_z <= (r_y == 8'hFF); r_n <= |((r_y + 8'd1) & SIGN_BIT);
                end
                K_DEX: begin
                    r_x <= r_x - 8'd1; r_z <= (r_x == 8'h01); r_n <= |((r_x - 8'd1) & SIGN_BIT);
                end
                K_DEY: begin
                    r_y <= r_y - 8'd1; r_z <= (r_y == 8'h01); r_n <= |((r_y - 8'd1) & SIGN_BIT);
                end
                K_TAX: begin
                    r_x <= r_a; r_z <= (r_a == 8'h00); r_n <= r_a[7];
                end
                K_TAY: begin
                    r_y <= r_a; r_z <= (r_a == 8'h00); r_n <= r_a[7];
                end
                K_TXA: begin
                    r_a <= r_x; r_z <= (r_x == 8'h00); r_n <= r_x[7];
                end
                K_TYA: begin
                    r_a <= r_y; r_z <= (r_y == 8'h00); r_n <= r_y[7];
                end
                K_TXS: r_s <= r_x;
                K_TSX: begin
                    r_x <= r_s; r_z <= (r_s == 8'h00); r_n <= r_s[7];
                end
                default: ;
            endcase
        end
    end

    assign o_acc_value    = r_a;
    assign o_x_value      = r_x;
    assign o_y_value      = r_y;
    assign o_stack_value  = r_s;
    assign o_zero_out     = r_z;
    assign o_negative_out = r_n;
endmodule

/* hw/rtl/cpu8_load_store_logic_unit.sv */
// Top level of the 8-bit CPU load/store, inc/dec and logic unit.
// This unit executes one already-fetched instruction per item: the opcode and
// its two operand bytes go in, and one result item comes out with A, X, Y, S,
// the Z and N flags, the effective address and the memory byte read or written.
// All accesses share a single-port data memory of 2**MEM_ADDR_BITS bytes, so
// an item steps through the states PLO, EA, RD, EXEC and OUT from acceptance
// to result for direct and implied modes, and through PLO, PHI, PWAIT, EA,
// RD, EXEC and OUT for the two indirect modes, which first read the two
// pointer bytes; only after the result is taken does the unit return to IDLE
// and accept the next item, so items do not overlap, and a stalled result
// holds the unit. After reset a clearing pass writes zero to every memory
// byte, one per cycle, before the first item is accepted.
module cpu8_load_store_logic_unit #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_operand_low,
    input  logic [7:0]  i_operand_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_acc_value,
    output logic [7:0]  o_x_value,
    output logic [7:0]  o_y_value,
    output logic [7:0]  o_stack_value,
    output logic        o_zero_out,
    output logic        o_negative_out,
    output logic [15:0] o_effective_address,
    output logic [7:0]  o_memory_byte,
    output logic        o_illegal_opcode
);
    import cpu8_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller sequences the memory port; the datapath holds all state.
    cpu8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cpu8_dpath #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_opcode            (i_opcode),
        .i_operand_low       (i_operand_low),
        .i_operand_high      (i_operand_high),
        .o_acc_value         (o_acc_value),
        .o_x_value           (o_x_value),
        .o_y_value           (o_y_value),
        .o_stack_value       (o_stack_value),
        .o_zero_out          (o_zero_out),
        .o_negative_out      (o_negative_out),
        .o_effective_address (o_effective_address),
        .o_memory_byte       (o_memory_byte),
        .o_illegal_opcode    (o_illegal_opcode)
    );
endmodule

/* test/tb_cpu8_load_store_logic_unit.sv */
// Testbench of the 8-bit CPU load/store, inc/dec and logic unit.
`timescale 1ns / 1ps

module tb_cpu8_load_store_logic_unit;
    import cpu8_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_opcode = '0;
    logic [7:0]  i_operand_low = '0;
    logic [7:0]  i_operand_high = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_acc_value;
    logic [7:0]  o_x_value;
    logic [7:0]  o_y_value;
    logic [7:0]  o_stack_value;
    logic        o_zero_out;
    logic        o_negative_out;
    logic [15:0] o_effective_address;
    logic [7:0]  o_memory_byte;
    logic        o_illegal_opcode;

    cpu8_load_store_logic_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    // One expected outcome of an instruction, packed in output order.
    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic        z;
        logic        n;
        logic [15:0] ea;
        logic [7:0]  mb;
        logic        bad;
    } t_outcome;

    // Shadow machine state kept by the predictor.
    logic [7:0] shadow_mem [0:65535];
    logic [7:0] sh_a, sh_x, sh_y, sh_s;
    logic       sh_z, sh_n;

    t_outcome pending_outcomes[$];
    int       mismatch_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    longint   cycle_count = 0;

    // The legal opcodes, so random traffic mostly hits the supported subset.
    logic [7:0] legal_ops[$] = '{
        8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1, 8'hA2, 8'hA6,
        8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'h85, 8'h95,
        8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91, 8'h86, 8'h96, 8'h8E, 8'h84, 8'h94,
        8'h8C, 8'hE6, 8'hF6, 8'hEE, 8'hFE, 8'hC6, 8'hD6, 8'hCE, 8'hDE, 8'h29,
        8'h25, 8'h35, 8'h2D, 8'h49, 8'h45, 8'h55, 8'h4D, 8'h09, 8'h05, 8'h15,
        8'h0D, 8'hE8, 8'hC8, 8'hCA, 8'h88, 8'hAA, 8'hA8, 8'h8A, 8'h98, 8'h9A,
        8'hBA};

    function automatic void flags_from(input logic [7:0] v);
        sh_z = (v == 8'h00);
        sh_n = (v & SIGN_BIT) != 0;
    endfunction

    // Executes one instruction on the shadow state and returns the outcome.
    function automatic t_outcome execute_instruction(input logic [7:0] op,
                                                     input logic [7:0] lo,
                                                     input logic [7:0] hi);
        t_kind      kind;
        t_mode      mode;
        t_reg       rsel;
        logic [15:0] ea;
        logic [7:0]  mb, v, ptr, src;
        t_outcome    o;
        kind = K_BAD; mode = M_IMP; rsel = R_A;
        case (op)
            8'hA9: begin kind = K_LD; mode = M_IMM; end
            8'hA5: begin kind = K_LD; mode = M_ZP; end
            8'hB5: begin kind = K_LD; mode = M_ZPX; end
            8'hAD: begin kind = K_LD; mode = M_ABS; end
            8'hBD: begin kind = K_LD; mode = M_ABX; end
            8'hB9: begin kind = K_LD; mode = M_ABY; end
            8'hA1: begin kind = K_LD; mode = M_IZX; end
            8'hB1: begin kind = K_LD; mode = M_IZY; end
            8'hA2: begin kind = K_LD; mode = M_IMM; rsel = R_X; end
            8'hA6: begin kind = K_LD; mode = M_ZP;  rsel = R_X; end
            8'hB6: begin kind = K_LD; mode = M_ZPY; rsel = R_X; end
            8'hAE: begin kind = K_LD; mode = M_ABS; rsel = R_X; end
            8'hBE: begin kind = K_LD; mode = M_ABY; rsel = R_X; end
            8'hA0: begin kind = K_LD; mode = M_IMM; rsel = R_Y; end
            8'hA4: begin kind = K_LD; mode = M_ZP;  rsel = R_Y; end
            8'hB4: begin kind = K_LD; mode = M_ZPX; rsel = R_Y; end
            8'hAC: begin kind = K_LD; mode = M_ABS; rsel = R_Y; end
            8'hBC: begin kind = K_LD; mode = M_ABX; rsel = R_Y; end
            8'h85: begin kind = K_ST; mode = M_ZP; end
            8'h95: begin kind = K_ST; mode = M_ZPX; end
            8'h8D: begin kind = K_ST; mode = M_ABS; end
            8'h9D: begin kind = K_ST; mode = M_ABX; end
            8'h99: begin kind = K_ST; mode = M_ABY; end
            8'h81: begin kind = K_ST; mode = M_IZX; end
            8'h91: begin kind = K_ST; mode = M_IZY; end
            8'h86: begin kind = K_ST; mode = M_ZP;  rsel = R_X; end
            8'h96: begin kind = K_ST; mode = M_ZPY; rsel = R_X; end
            8'h8E: begin kind = K_ST; mode = M_ABS; rsel = R_X; end
            8'h84: begin kind = K_ST; mode = M_ZP;  rsel = R_Y; end
            8'h94: begin kind = K_ST; mode = M_ZPX; rsel = R_Y; end
            8'h8C: begin kind = K_ST; mode = M_ABS; rsel = R_Y; end
            8'hE6: begin kind = K_INC; mode = M_ZP; end
            8'hF6: begin kind = K_INC; mode = M_ZPX; end
            8'hEE: begin kind = K_INC; mode = M_ABS; end
            8'hFE: begin kind = K_INC; mode = M_ABX; end
            8'hC6: begin kind = K_DEC; mode = M_ZP; end
            8'hD6: begin kind = K_DEC; mode = M_ZPX; end
            8'hCE: begin kind = K_DEC; mode = M_ABS; end
            8'hDE: begin kind = K_DEC; mode = M_ABX; end
            8'h29: begin kind = K_AND; mode = M_IMM; end
            8'h25: begin kind = K_AND; mode = M_ZP; end
            8'h35: begin kind = K_AND; mode = M_ZPX; end
            8'h2D: begin kind = K_AND; mode = M_ABS; end
            8'h49: begin kind = K_EOR; mode = M_IMM; end
            8'h45: begin kind = K_EOR; mode = M_ZP; end
            8'h55: begin kind = K_EOR; mode = M_ZPX; end
            8'h4D: begin kind = K_EOR; mode = M_ABS; end
            8'h09: begin kind = K_ORA; mode = M_IMM; end
            8'h05: begin kind = K_ORA; mode = M_ZP; end
            8'h15: begin kind = K_ORA; mode = M_ZPX; end
            8'h0D: begin kind = K_ORA; mode = M_ABS; end
            8'hE8: kind = K_INX;
            8'hC8: kind = K_INY;
            8'hCA: kind = K_DEX;
            8'h88: kind = K_DEY;
            8'hAA: kind = K_TAX;
            8'hA8: kind = K_TAY;
            8'h8A: kind = K_TXA;
            8'h98: kind = K_TYA;
            8'h9A: kind = K_TXS;
            8'hBA: kind = K_TSX;
            default: kind = K_BAD;
        endcase
        ea = '0;
        mb = '0;
        if (kind != K_BAD && mode != M_IMP && mode != M_IMM) begin
            case (mode)
                M_ZP:  ea = {8'h00, lo};
                M_ZPX: ea = {8'h00, 8'(lo + sh_x)};
                M_ZPY: ea = {8'h00, 8'(lo + sh_y)};
                M_ABS: ea = {hi, lo};
                M_ABX: ea = {hi, lo} + 16'(sh_x);
                M_ABY: ea = {hi, lo} + 16'(sh_y);
                M_IZX: begin
                    ptr = lo + sh_x;
                    ea = {shadow_mem[8'(ptr + 8'd1)], shadow_mem[ptr]};
                end
                M_IZY: ea = {shadow_mem[8'(lo + 8'd1)], shadow_mem[lo]} + 16'(sh_y);
                default: ea = '0;
            endcase
            mb = shadow_mem[ea];
        end
        v = (mode == M_IMM) ? lo : mb;
        src = (rsel == R_X) ? sh_x : (rsel == R_Y) ? sh_y : sh_a;
        case (kind)
            K_LD: begin
                case (rsel)
                    R_X: sh_x = v;
                    R_Y: sh_y = v;
                    default: sh_a = v;
                endcase
                flags_from(v);
            end
            K_ST: begin shadow_mem[ea] = src; mb = src; end
            K_INC: begin mb = mb + 8'd1; shadow_mem[ea] = mb; flags_from(mb); end
            K_DEC: begin mb = mb - 8'd1; shadow_mem[ea] = mb; flags_from(mb); end
            K_AND: begin sh_a = sh_a & v; flags_from(sh_a); end
            K_EOR: begin sh_a = sh_a ^ v; flags_from(sh_a); end
            K_ORA: begin sh_a = sh_a | v; flags_from(sh_a); end
            K_INX: begin sh_x = sh_x + 8'd1; flags_from(sh_x); end
            K_INY: begin sh_y = sh_y + 8'd1; flags_from(sh_y); end
            K_DEX: begin sh_x = sh_x - 8'd1; flags_from(sh_x); end
            K_DEY: begin sh_y = sh_y - 8'd1; flags_from(sh_y); end
            K_TAX: begin sh_x = sh_a; flags_from(sh_x); end
            K_TAY: begin sh_y = sh_a; flags_from(sh_y); end
            K_TXA: begin sh_a = sh_x; flags_from(sh_a); end
            K_TYA: begin sh_a = sh_y; flags_from(sh_a); end
            K_TXS: sh_s = sh_x;
            K_TSX: begin sh_x = sh_s; flags_from(sh_x); end
            default: ;
        endcase
        o = '{sh_a, sh_x, sh_y, sh_s, sh_z, sh_n, ea, mb, kind == K_BAD};
        return o;
    endfunction

    // Sends one item, idling first at the current rate. The valid is lowered
    // only when the next item will not follow at once.
    task automatic send_item(input logic [7:0] op, input logic [7:0] lo,
                             input logic [7:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_operand_low  <= lo;
        i_operand_high <= hi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outcomes.push_back(execute_instruction(op, lo, hi));
    endtask

    // Receiver stall pattern; drawn once per clock edge.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker: compares each accepted result with the oldest outcome.
    always @(posedge i_clk) begin
        t_outcome got, want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_acc_value, o_x_value, o_y_value, o_stack_value, o_zero_out,
                    o_negative_out, o_effective_address, o_memory_byte,
                    o_illegal_opcode};
            if (pending_outcomes.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("Unexpected result item: %h", got);
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("Mismatch: expected %h, actual %h", want, got);
                end
            end
        end
    end

    // Cycle limit covers the clearing pass plus every item at its slowest.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("cpu8_load_store_logic_unit verification failed");
            $finish;
        end
    end

    // Lowers the valid, then waits until every outstanding result has come.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Directed: extremes, every operation class, zero-page and address wraps,
    // both indirect modes, and an illegal opcode.
    task automatic test_directed();
        send_item(8'hA2, 8'hFF, 8'h00);  // LDX #FF
        send_item(8'hA0, 8'h80, 8'h00);  // LDY #80
        send_item(8'hA9, 8'h00, 8'h00);  // LDA #0 sets Z
        send_item(8'h95, 8'h02, 8'h00);  // STA zp,X wraps to 01
        send_item(8'h86, 8'hFF, 8'h00);  // STX FF, pointer high byte wraps
        send_item(8'h84, 8'h00, 8'h00);  // STY 00
        send_item(8'hA1, 8'h00, 8'h00);  // LDA (00,X) uses FF and 00
        send_item(8'hB1, 8'hFF, 8'h00);  // LDA (FF),Y
        send_item(8'h9D, 8'hFF, 8'hFF);  // STA abs,X wraps at 16 bits
        send_item(8'hFE, 8'hFF, 8'hFF);  // INC abs,X
        send_item(8'hCE, 8'h34, 8'h12);  // DEC of zero gives FF
        send_item(8'hAE, 8'h34, 8'h12);
        send_item(8'h09, 8'hA5, 8'h00);
        send_item(8'h29, 8'h0F, 8'h00);
        send_item(8'h49, 8'hFF, 8'h00);
        send_item(8'hE8, 8'h00, 8'h00);
        send_item(8'h88, 8'h00, 8'h00);
        send_item(8'h9A, 8'h00, 8'h00);  // TXS keeps flags
        send_item(8'hBA, 8'h00, 8'h00);
        send_item(8'hAA, 8'h00, 8'h00);
        send_item(8'h98, 8'h00, 8'h00);
        send_item(8'h02, 8'hFF, 8'hFF);  // unsupported opcode
        send_item(8'h91, 8'h10, 8'h00);  // STA (10),Y
        send_item(8'hBE, 8'hFF, 8'hFF);
    endtask

    // Random traffic: mostly supported opcodes, with addresses mostly kept in
    // pages 00 to 03 and FF, so loads and read-modify-writes see earlier stores.
    task automatic test_random(input int count);
        logic [7:0] op, lo, hi;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) op = 8'($urandom);
            else op = legal_ops[$urandom_range(legal_ops.size() - 1)];
            lo = 8'($urandom);
            case ($urandom_range(3))
                0: hi = 8'h00;
                1: hi = 8'hFF;
                2: hi = 8'($urandom_range(3));
                default: hi = 8'($urandom);
            endcase
            send_item(op, lo, hi);
        end
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic test_drain_pause();
        send_item(8'hE6, 8'h40, 8'h00);
        wait_drained();
        send_item(8'hA5, 8'h40, 8'h00);
    endtask

    initial begin
        for (int k = 0; k < 65536; k++) shadow_mem[k] = 8'h00;
        {sh_a, sh_x, sh_y, sh_s, sh_z, sh_n} = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 25; recv_stall_pct = 55;
        test_random(270);
        test_drain_pause();
        send_idle_pct = 55; recv_stall_pct = 25;
        test_random(270);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(260);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("cpu8_load_store_logic_unit verification clean");
        end else begin
            $display("cpu8_load_store_logic_unit verification failed");
        end
        $finish;
    end

endmodule
